// ----- rtl/brainfuck_interpreter_core_macros.svh -----
// Assertion macros for the checker file of the interpreter core.
`ifndef BRAINFUCK_INTERPRETER_CORE_MACROS_SVH
`define BRAINFUCK_INTERPRETER_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define BFI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfi_checker: same-cycle implication failed");

// Next-cycle implication, switched off while reset is high.
`define BFI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfi_checker: next-cycle implication failed");

`endif

// ----- rtl/bfi_pkg.sv -----
package bfi_pkg;

   // Storage sizes.
   localparam int TAPE_DEPTH    = 2048;
   localparam int PROGRAM_DEPTH = 1024;

   // Derived widths: addresses, and lengths that can also hold the depth itself.
   localparam int TAPE_AW = $clog2(TAPE_DEPTH);
   localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
   localparam int PROG_LW = $clog2(PROGRAM_DEPTH + 1);

   // Field widths.
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 2'd2;

   // Instruction characters.
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h5D;

endpackage

// ----- rtl/bfi_req_if.sv -----
// Request channel: one command word per handshake.
interface bfi_req_if import bfi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [BYTE_W-1:0]   program_byte;

   modport source (output valid, command, program_byte, input ready);
   modport sink   (input valid, command, program_byte, output ready);
endinterface

// ----- rtl/bfi_rsp_if.sv -----
// Response channel: one result word per handshake.
interface bfi_rsp_if import bfi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                out_valid;
   logic [BYTE_W-1:0]   out_byte;
   logic                halted;
   logic [STATUS_W-1:0] status;

   modport source (output valid, out_valid, out_byte, halted, status, input ready);
   modport sink   (input valid, out_valid, out_byte, halted, status, output ready);
endinterface

// ----- rtl/brainfuck_interpreter_core.sv -----
// Brainfuck interpreter core. Each request word is a command (load a program byte, execute
// one instruction, clear) and gives exactly one response word. The core handles one command
// at a time. It uses a program store with one write port and a registered read port, a
// single-port tape with registered read data, a bracket scan that reads one program byte
// per cycle through one shared pointer incrementer, and a tape sweep that zeroes one cell
// per cycle. After reset the same sweep covers every tape cell before the first request is
// taken. A finished response waits in an output register, so the core goes back to
// accepting requests while that word is still pending, and stalls only at the end of the
// next command if the previous word has not been taken.
module brainfuck_interpreter_core import bfi_pkg::*; (
   input logic        clock,
   input logic        reset,
   bfi_req_if.sink    req_chan,
   bfi_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_FWD,
      ST_SCAN_BWD,
      ST_DONE
   } state_type;

   localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);
   localparam logic [PROG_LW-1:0] PROG_FULL = PROG_LW'(PROGRAM_DEPTH);

   // Control state.
   state_type            state_ff, state_in;
   logic [PROG_LW-1:0]   prog_len_ff, prog_len_in;
   logic [PROG_LW-1:0]   pc_ff, pc_in;
   logic [TAPE_AW-1:0]   dp_ff, dp_in;
   logic                 error_ff, error_in;
   logic [TAPE_AW-1:0]   clr_addr_ff, clr_addr_in;
   logic                 clr_cmd_ff, clr_cmd_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working and payload registers.
   logic [PROG_LW-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [PROG_LW-1:0]   depth_ff, depth_in;
   logic                 full_ff, full_in;
   logic                 emit_ff, emit_in;
   logic [BYTE_W-1:0]    emit_byte_ff, emit_byte_in;
   logic                 rsp_out_valid_ff, rsp_out_valid_in;
   logic [BYTE_W-1:0]    rsp_out_byte_ff, rsp_out_byte_in;
   logic                 rsp_halted_ff, rsp_halted_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Memories and their registered read data.
   logic [BYTE_W-1:0]    prog_mem_ff [PROGRAM_DEPTH];
   logic [BYTE_W-1:0]    prog_q_ff;
   logic [BYTE_W-1:0]    tape_mem_ff [TAPE_DEPTH];
   logic [BYTE_W-1:0]    tape_q_ff;

   // Memory access controls.
   logic                 prog_we;
   logic [PROG_AW-1:0]   prog_waddr;
   logic [PROG_AW-1:0]   prog_raddr;
   logic                 tape_we;
   logic [TAPE_AW-1:0]   tape_addr;
   logic [BYTE_W-1:0]    tape_wdata;

   // Shared pointer step unit and bracket depth arithmetic.
   logic [PROG_LW-1:0]   step_a;
   logic                 step_down;
   logic [PROG_LW-1:0]   step_out;
   logic [PROG_LW-1:0]   depth_inc;
   logic [PROG_LW-1:0]   depth_dec;
   logic                 rsp_take;

   // The step unit serves the length on a load, the counter on execution and the scan pointer.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: step_a = prog_len_ff;
         ST_EXEC: step_a = pc_ff;
         default: step_a = scan_ptr_ff;
      endcase
      step_down = (state_ff == ST_SCAN_BWD);
      step_out  = step_down ? step_a - PROG_LW'(1) : step_a + PROG_LW'(1);
   end

   assign depth_inc = depth_ff + PROG_LW'(1);
   assign depth_dec = (depth_ff != '0) ? depth_ff - PROG_LW'(1) : '0;
   assign rsp_take  = rsp_valid_ff && rsp_chan.ready;
   assign prog_waddr = prog_len_ff[PROG_AW-1:0];

   // Sequencer next-state logic.
   always_comb begin
      state_in         = state_ff;
      prog_len_in      = prog_len_ff;
      pc_in            = pc_ff;
      dp_in            = dp_ff;
      error_in         = error_ff;
      clr_addr_in      = clr_addr_ff;
      clr_cmd_in       = clr_cmd_ff;
      scan_ptr_in      = scan_ptr_ff;
      depth_in         = depth_ff;
      full_in          = full_ff;
      emit_in          = emit_ff;
      emit_byte_in     = emit_byte_ff;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_halted_in    = rsp_halted_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_valid_in     = rsp_take ? 1'b0 : rsp_valid_ff;

      prog_we    = 1'b0;
      prog_raddr = pc_ff[PROG_AW-1:0];
      tape_we    = 1'b0;
      tape_addr  = dp_ff;
      tape_wdata = '0;

      unique case (state_ff)
         // Zero one tape cell per cycle.
         ST_CLEAR: begin
            tape_addr = clr_addr_ff;
            tape_we   = 1'b1;
            if (clr_addr_ff == TAPE_LAST) begin
               state_in = clr_cmd_ff ? ST_DONE : ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + TAPE_AW'(1);
            end
         end

         // Take a command; reads of program and tape at the counters start here.
         ST_IDLE: begin
            if (req_chan.valid) begin
               full_in      = 1'b0;
               emit_in      = 1'b0;
               emit_byte_in = '0;
               state_in     = ST_DONE;
               unique case (req_chan.command)
                  CMD_LOAD: begin
                     if (prog_len_ff == PROG_FULL) begin
                        full_in = 1'b1;
                     end else begin
                        prog_we     = 1'b1;
                        prog_len_in = step_out;
                     end
                  end
                  CMD_TICK: begin
                     if (!error_ff && (pc_ff < prog_len_ff)) begin
                        state_in = ST_EXEC;
                     end
                  end
                  CMD_CLEAR: begin
                     prog_len_in = '0;
                     pc_in       = '0;
                     dp_in       = '0;
                     error_in    = 1'b0;
                     clr_addr_in = '0;
                     clr_cmd_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Decode the instruction against the current cell.
         ST_EXEC: begin
            pc_in    = step_out;
            state_in = ST_DONE;
            priority if (prog_q_ff == CHAR_PLUS) begin
               tape_we    = 1'b1;
               tape_wdata = tape_q_ff + BYTE_W'(1);
            end else if (prog_q_ff == CHAR_MINUS) begin
               tape_we    = 1'b1;
               tape_wdata = tape_q_ff - BYTE_W'(1);
            end else if (prog_q_ff == CHAR_RIGHT) begin
               dp_in = (dp_ff == TAPE_LAST) ? '0 : dp_ff + TAPE_AW'(1);
            end else if (prog_q_ff == CHAR_LEFT) begin
               dp_in = (dp_ff == '0) ? TAPE_LAST : dp_ff - TAPE_AW'(1);
            end else if (prog_q_ff == CHAR_DOT) begin
               emit_in      = 1'b1;
               emit_byte_in = tape_q_ff;
            end else if ((prog_q_ff == CHAR_OPEN) && (tape_q_ff == '0)) begin
               pc_in       = pc_ff;
               scan_ptr_in = pc_ff;
               depth_in    = '0;
               prog_raddr  = pc_ff[PROG_AW-1:0];
               state_in    = ST_SCAN_FWD;
            end else if ((prog_q_ff == CHAR_CLOSE) && (tape_q_ff != '0)) begin
               pc_in       = pc_ff;
               scan_ptr_in = pc_ff;
               depth_in    = '0;
               prog_raddr  = pc_ff[PROG_AW-1:0];
               state_in    = ST_SCAN_BWD;
            end else begin
               state_in = ST_DONE;
            end
         end

         // Walk forward one byte per cycle looking for the matching close bracket.
         ST_SCAN_FWD: begin
            scan_ptr_in = step_out;
            prog_raddr  = step_out[PROG_AW-1:0];
            if (scan_ptr_ff >= prog_len_ff) begin
               pc_in    = prog_len_ff;
               state_in = ST_DONE;
            end else if (prog_q_ff == CHAR_OPEN) begin
               depth_in = depth_inc;
            end else if (prog_q_ff == CHAR_CLOSE) begin
               depth_in = depth_dec;
               if (depth_dec == '0) begin
                  pc_in    = step_out;
                  state_in = ST_DONE;
               end
            end
         end

         // Walk backward one byte per cycle looking for the matching open bracket.
         ST_SCAN_BWD: begin
            scan_ptr_in = step_out;
            prog_raddr  = step_out[PROG_AW-1:0];
            if ((prog_q_ff == CHAR_OPEN) && (depth_dec == '0)) begin
               pc_in    = scan_ptr_ff;
               state_in = ST_DONE;
            end else if (scan_ptr_ff == '0) begin
               error_in = 1'b1;
               state_in = ST_DONE;
            end else if (prog_q_ff == CHAR_CLOSE) begin
               depth_in = depth_inc;
            end else if (prog_q_ff == CHAR_OPEN) begin
               depth_in = depth_dec;
            end
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_out_valid_in = emit_ff;
               rsp_out_byte_in  = emit_byte_ff;
               rsp_halted_in    = error_ff || (pc_ff >= prog_len_ff);
               if (full_ff) begin
                  rsp_status_in = STATUS_FULL;
               end else if (error_ff) begin
                  rsp_status_in = STATUS_UNMATCHED;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               clr_cmd_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      scan_ptr_ff      <= scan_ptr_in;
      depth_ff         <= depth_in;
      full_ff          <= full_in;
      emit_ff          <= emit_in;
      emit_byte_ff     <= emit_byte_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_halted_ff    <= rsp_halted_in;
      rsp_status_ff    <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         prog_len_ff  <= '0;
         pc_ff        <= '0;
         dp_ff        <= '0;
         error_ff     <= 1'b0;
         clr_addr_ff  <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prog_len_ff  <= prog_len_in;
         pc_ff        <= pc_in;
         dp_ff        <= dp_in;
         error_ff     <= error_in;
         clr_addr_ff  <= clr_addr_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Program store: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem_ff[prog_waddr] <= req_chan.program_byte;
      end
      prog_q_ff <= prog_mem_ff[prog_raddr];
   end

   // Tape: single port, read data registered.
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem_ff[tape_addr] <= tape_wdata;
      end
      tape_q_ff <= tape_mem_ff[tape_addr];
   end

   // Channel outputs.
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_valid = rsp_out_valid_ff;
   assign rsp_chan.out_byte  = rsp_out_byte_ff;
   assign rsp_chan.halted    = rsp_halted_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule

// ----- rtl/bfi_checker.sv -----
`include "brainfuck_interpreter_core_macros.svh"

module bfi_checker import bfi_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_out_valid,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_halted,
   input logic [STATUS_W-1:0] rsp_status
);

   // A stalled response word holds.
   `BFI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_valid) && $stable(rsp_out_byte) && $stable(rsp_halted) && $stable(rsp_status))

   // The core leaves the idle state on each accept, so ready drops after it.
   `BFI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // An emitted byte comes from a clean tick: no store-full or bracket error status.
   `BFI_ASSERT_IMPLY(a_emit_status_ok, clock, reset, rsp_valid && rsp_out_valid, rsp_status == STATUS_OK)

   // Without an emitted byte the byte field reads zero.
   `BFI_ASSERT_IMPLY(a_quiet_byte_zero, clock, reset, rsp_valid && !rsp_out_valid, rsp_out_byte == '0)

   // A bracket error always leaves the machine halted.
   `BFI_ASSERT_IMPLY(a_error_halts, clock, reset, rsp_valid && (rsp_status == STATUS_UNMATCHED), rsp_halted)

endmodule

bind brainfuck_interpreter_core bfi_checker u_bfi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_valid (rsp_chan.out_valid),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_halted    (rsp_chan.halted),
   .rsp_status    (rsp_chan.status)
);

// ----- dv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bfi_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 8;
   // The limit must outlast the clearing sweep, the longest bracket scan and the
   // receiver's long hold-off.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_ITEMS   = 700;
   localparam int MAX_REPORTS    = 100;

   // The command code that the core does not define.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic                out_valid;
      logic [BYTE_W-1:0]   out_byte;
      logic                halted;
      logic [STATUS_W-1:0] status;
   } result_word_type;

   typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfi_req_if req_bus ();
   bfi_rsp_if rsp_bus ();

   brainfuck_interpreter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Machine state as the testbench expects it to be after every accepted word.
   logic [BYTE_W-1:0] prog_img [PROGRAM_DEPTH];
   logic [BYTE_W-1:0] tape_img [TAPE_DEPTH] = '{default: '0};
   int                model_len      = 0;
   int                model_pc       = 0;
   int                model_dp       = 0;
   bit                unmatched_stop = 1'b0;

   result_word_type awaited_results [$];
   result_word_type want;
   int              mismatch_count = 0;
   int              items_sent     = 0;
   int              burst_left     = 0;
   int              idle_cycles    = 0;
   bit              hold_request   = 1'b0;

   function automatic bit machine_halted();
      return unmatched_stop || (model_pc >= model_len);
   endfunction

   // Applies one command word to the expected machine state and returns the result word.
   function automatic result_word_type step_machine(input logic [CMD_W-1:0]  cmd,
                                                    input logic [BYTE_W-1:0] pbyte);
      result_word_type   r;
      logic [BYTE_W-1:0] op;
      bit                store_full;
      int                next_pc;
      int                depth;
      int                match;
      int                p;
      r          = '0;
      store_full = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            if (model_len >= PROGRAM_DEPTH) begin
               store_full = 1'b1;
            end else begin
               prog_img[model_len] = pbyte;
               model_len++;
            end
         end
         CMD_TICK: begin
            if (!unmatched_stop && model_pc < model_len) begin
               op      = prog_img[model_pc];
               next_pc = model_pc + 1;
               if (op == CHAR_PLUS) begin
                  tape_img[model_dp] = tape_img[model_dp] + 8'd1;
               end else if (op == CHAR_MINUS) begin
                  tape_img[model_dp] = tape_img[model_dp] - 8'd1;
               end else if (op == CHAR_RIGHT) begin
                  model_dp = (model_dp + 1 >= TAPE_DEPTH) ? 0 : model_dp + 1;
               end else if (op == CHAR_LEFT) begin
                  model_dp = (model_dp == 0) ? TAPE_DEPTH - 1 : model_dp - 1;
               end else if (op == CHAR_DOT) begin
                  r.out_valid = 1'b1;
                  r.out_byte  = tape_img[model_dp];
               end else if (op == CHAR_OPEN && tape_img[model_dp] == '0) begin
                  // Walk forward with a nesting count to the matching closing bracket.
                  match = model_len;
                  depth = 0;
                  for (p = model_pc; p < model_len && match == model_len; p++) begin
                     if (prog_img[p] == CHAR_OPEN) begin
                        depth++;
                     end else if (prog_img[p] == CHAR_CLOSE) begin
                        if (depth != 0) depth--;
                        if (depth == 0) match = p;
                     end
                  end
                  next_pc = (match >= model_len) ? model_len : match + 1;
               end else if (op == CHAR_CLOSE && tape_img[model_dp] != '0) begin
                  // Walk back to the matching opening bracket; none found is an error stop.
                  match = -1;
                  depth = 0;
                  for (p = model_pc; p >= 0 && match < 0; p--) begin
                     if (prog_img[p] == CHAR_CLOSE) begin
                        depth++;
                     end else if (prog_img[p] == CHAR_OPEN) begin
                        if (depth != 0) depth--;
                        if (depth == 0) match = p;
                     end
                  end
                  if (match >= 0) begin
                     next_pc = match;
                  end else begin
                     unmatched_stop = 1'b1;
                     next_pc        = model_pc;
                  end
               end
               model_pc = next_pc;
            end
         end
         CMD_CLEAR: begin
            foreach (tape_img[i]) tape_img[i] = '0;
            model_len      = 0;
            model_pc       = 0;
            model_dp       = 0;
            unmatched_stop = 1'b0;
         end
         default: begin
         end
      endcase
      r.halted = machine_halted();
      if (store_full) r.status = STATUS_FULL;
      else if (unmatched_stop) r.status = STATUS_UNMATCHED;
      else r.status = STATUS_OK;
      return r;
   endfunction

   // Sends one command word in bursts with random rests between them, and records the
   // expected result once the word has been accepted.
   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] pbyte);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.program_byte <= pbyte;
      do @(posedge clock); while (!req_bus.ready);
      // Ticks on a halted machine and undefined commands change nothing.
      if (!(cmd == CMD_UNUSED || (cmd == CMD_TICK && machine_halted()))) items_sent++;
      awaited_results.push_back(step_machine(cmd, pbyte));
   endtask

   // The sender rests until every outstanding result word has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_text(input string text);
      for (int i = 0; i < text.len(); i++) issue_command(CMD_LOAD, text[i]);
   endtask

   task automatic run_ticks(input int budget);
      int n;
      n = 0;
      while (!machine_halted() && n < budget) begin
         issue_command(CMD_TICK, BYTE_W'($urandom));
         n++;
      end
   endtask

   // Loads a random program; a well-formed one keeps its brackets balanced and shallow.
   task automatic load_random_program(input int length, input bit well_formed);
      logic [BYTE_W-1:0] op;
      int                open_count;
      open_count = 0;
      for (int i = 0; i < length; i++) begin
         case ($urandom_range(0, 11))
            0, 1, 2: op = CHAR_PLUS;
            3:       op = CHAR_MINUS;
            4:       op = CHAR_RIGHT;
            5:       op = CHAR_LEFT;
            6:       op = CHAR_DOT;
            7, 8:    op = CHAR_OPEN;
            9, 10:   op = CHAR_CLOSE;
            default: op = BYTE_W'($urandom);
         endcase
         if (well_formed) begin
            if (op == CHAR_OPEN && open_count >= 3) op = CHAR_PLUS;
            if (op == CHAR_CLOSE && open_count == 0) op = CHAR_DOT;
         end
         if (op == CHAR_OPEN) open_count++;
         else if (op == CHAR_CLOSE && open_count > 0) open_count--;
         issue_command(CMD_LOAD, op);
         // A decrement straight after an opening bracket lets most loops run out.
         if (well_formed && op == CHAR_OPEN) issue_command(CMD_LOAD, CHAR_MINUS);
      end
      if (well_formed) begin
         while (open_count > 0) begin
            issue_command(CMD_LOAD, CHAR_CLOSE);
            open_count--;
         end
      end
   endtask

   // Plain instructions, both pointer wraps, skipped bytes, halting and resuming.
   task automatic test_basic_ops();
      issue_command(CMD_TICK, 8'hFF);
      issue_command(CMD_UNUSED, 8'hA5);
      load_text("-.<+.>");
      issue_command(CMD_LOAD, 8'h00);
      issue_command(CMD_LOAD, 8'hFF);
      run_ticks(20);
      issue_command(CMD_TICK, 8'h00);
      issue_command(CMD_LOAD, CHAR_DOT);
      run_ticks(4);
      wait_for_results();
   endtask

   // Skipping a nested loop, a jump back, an unmatched closing and an unmatched opening bracket.
   task automatic test_brackets();
      issue_command(CMD_CLEAR, 8'h5A);
      load_text("[[]]++[-]+]");
      run_ticks(20);
      issue_command(CMD_TICK, 8'h00);
      issue_command(CMD_CLEAR, 8'h00);
      load_text("[[]");
      run_ticks(4);
      wait_for_results();
   endtask

   // Fills the program store while the receiver holds off, loads past the end, then sends
   // one bracket on a scan across the whole store.
   task automatic test_store_full();
      logic [BYTE_W-1:0] filler;
      issue_command(CMD_CLEAR, 8'h00);
      hold_request = 1'b1;
      issue_command(CMD_LOAD, CHAR_OPEN);
      for (int i = 0; i < PROGRAM_DEPTH - 2; i++) begin
         filler = BYTE_W'($urandom);
         if (filler == CHAR_OPEN || filler == CHAR_CLOSE) filler = CHAR_PLUS;
         issue_command(CMD_LOAD, filler);
      end
      issue_command(CMD_LOAD, CHAR_CLOSE);
      issue_command(CMD_LOAD, 8'hFF);
      issue_command(CMD_LOAD, 8'h00);
      run_ticks(2);
      issue_command(CMD_TICK, 8'h3C);
      wait_for_results();
   endtask

   // Mostly well-formed programs with random content; the rest are broken programs, noise
   // and commands that cut into a running program.
   task automatic test_random_programs();
      int start_count;
      int roll;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if (!machine_halted() || unmatched_stop || model_len > PROGRAM_DEPTH - 100 ||
             $urandom_range(0, 7) == 0) begin
            issue_command(CMD_CLEAR, BYTE_W'($urandom));
         end
         roll = $urandom_range(0, 9);
         if (roll < 6) begin
            load_random_program($urandom_range(4, 30), 1'b1);
            run_ticks(80);
         end else if (roll == 6) begin
            load_random_program($urandom_range(2, 20), 1'b0);
            run_ticks(60);
         end else if (roll == 7) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 2))
                  0:       issue_command(CMD_LOAD, BYTE_W'($urandom));
                  1:       issue_command(CMD_TICK, BYTE_W'($urandom));
                  default: issue_command(CMD_UNUSED, BYTE_W'($urandom));
               endcase
            end
            run_ticks(20);
         end else begin
            load_random_program($urandom_range(4, 16), 1'b1);
            run_ticks($urandom_range(1, 10));
            issue_command(CMD_UNUSED, BYTE_W'($urandom));
            load_random_program($urandom_range(1, 8), 1'b1);
            if ($urandom_range(0, 3) == 0) issue_command(CMD_CLEAR, BYTE_W'($urandom));
            run_ticks(60);
         end
         if ($urandom_range(0, 15) == 0) wait_for_results();
      end
   endtask

   // Stimulus: reset, then each test in turn.
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_UNUSED;
      req_bus.program_byte <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_brackets();
      test_store_full();
      test_random_programs();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // The receiver changes its stall pattern every so often, and holds off for a long
   // stretch when a test asks for it.
   initial begin
      rx_mode_type rx_mode;
      int          rx_left;
      rx_mode = RX_STEADY;
      rx_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            case (rx_mode)
               RX_STEADY:   rsp_bus.ready <= 1'b1;
               RX_RANDOM:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               default:     rsp_bus.ready <= (rx_left % 5 != 0);
            endcase
         end
      end
   end

   // Later mismatches are counted but not printed, to keep the log short.
   task automatic note_mismatch(input string field, input logic [BYTE_W-1:0] want_v,
                                input logic [BYTE_W-1:0] got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      end
   endtask

   // Each result word is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: result word with none expected, expected none, actual %0h/%0h/%0h/%0h",
                        $time, rsp_bus.out_valid, rsp_bus.out_byte, rsp_bus.halted,
                        rsp_bus.status);
            end
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.out_valid !== want.out_valid)
               note_mismatch("out_valid", BYTE_W'(want.out_valid), BYTE_W'(rsp_bus.out_valid));
            if (rsp_bus.out_byte !== want.out_byte)
               note_mismatch("out_byte", want.out_byte, rsp_bus.out_byte);
            if (rsp_bus.halted !== want.halted)
               note_mismatch("halted", BYTE_W'(want.halted), BYTE_W'(rsp_bus.halted));
            if (rsp_bus.status !== want.status)
               note_mismatch("status", BYTE_W'(want.status), BYTE_W'(rsp_bus.status));
         end
      end
   end

   // The run ends if no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
